// ===== design/tkrt_pkg.sv =====
// Package with the constants and types of the top-k ranking table.
package tkrt_pkg;

  localparam int RankSlots = 16;
  localparam int IdW       = 32;
  localparam int ScoreW    = 32;
  localparam int FuncW     = 2;
  localparam int RankW     = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef logic [IdW-1:0]           id_t;
  typedef logic signed [ScoreW-1:0] score_t;
  typedef logic [RankW-1:0]         rank_t;

endpackage

// ===== design/tkrt_if.sv =====
// Request and response channel interfaces of the top-k ranking table.
interface tkrt_req_if import tkrt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  id_t              player_id;
  score_t           score;

  modport source (output valid, output func, output player_id, output score, input ready);
  modport sink (input valid, input func, input player_id, input score, output ready);
endinterface

interface tkrt_rsp_if import tkrt_pkg::*;;
  logic  valid;
  logic  ready;
  rank_t rank;

  modport source (output valid, output rank, input ready);
  modport sink (input valid, input rank, output ready);
endinterface

// ===== design/top_k_ranking_table_top.sv =====
// Top-k ranking table: sorted insertion, identifier lookup and clear.
// A request is registered, then handled against every slot of the table at once.
// A query response is registered from the request register once the response register has space.
// One request is accepted every cycle unless a query waits on a full response register.
// Reset empties the table: all slots read as identifier 0 with score 0.
module top_k_ranking_table_top import tkrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tkrt_req_if.sink    req_i,
  tkrt_rsp_if.source  rsp_o
);

  logic                 s1_valid_q;
  logic [FuncW-1:0]     s1_func_q;
  id_t                  s1_id_q;
  score_t               s1_score_q;

  id_t                  slot_id_q    [RankSlots];
  id_t                  slot_id_d    [RankSlots];
  score_t               slot_score_q [RankSlots];
  score_t               slot_score_d [RankSlots];
  logic [RankSlots-1:0] slot_valid_q;
  logic [RankSlots-1:0] slot_valid_d;
  logic [RankSlots-1:0] ge;

  logic                 out_valid_q;
  rank_t                out_rank_q;
  rank_t                rank_d;
  logic                 found;
  logic                 out_space;
  logic                 s1_adv;
  logic                 is_query;

  assign is_query  = (s1_func_q == FUNC_QUERY);
  assign out_space = !out_valid_q || rsp_o.ready;
  assign s1_adv    = s1_valid_q && (!is_query || out_space);
  assign req_i.ready = !s1_valid_q || s1_adv;

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.rank  = out_rank_q;

  always_comb begin
    rank_d = '0;
    found  = 1'b0;
    for (int i = 0; i < RankSlots; i++) begin
      if (!found && slot_id_q[i] == s1_id_q) begin
        found  = 1'b1;
        rank_d = RankW'(i + 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < RankSlots; i++) begin
      ge[i] = slot_valid_q[i] && (slot_score_q[i] >= s1_score_q);
    end
  end

  always_comb begin
    slot_id_d    = slot_id_q;
    slot_score_d = slot_score_q;
    slot_valid_d = slot_valid_q;
    if (s1_adv) begin
      unique case (s1_func_q)
        FUNC_INSERT: begin
          // Entries that rank at or above the new one stay; the rest move down one slot.
          for (int i = 0; i < RankSlots; i++) begin
            if (!ge[i]) begin
              if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
                slot_id_d[i]    = s1_id_q;
                slot_score_d[i] = s1_score_q;
                slot_valid_d[i] = 1'b1;
              end else begin
                slot_id_d[i]    = slot_id_q[(i == 0) ? 0 : i - 1];
                slot_score_d[i] = slot_score_q[(i == 0) ? 0 : i - 1];
                slot_valid_d[i] = slot_valid_q[(i == 0) ? 0 : i - 1];
              end
            end
          end
        end
        FUNC_CLEAR: begin
          for (int i = 0; i < RankSlots; i++) begin
            slot_id_d[i]    = '0;
            slot_score_d[i] = '0;
          end
          slot_valid_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      slot_valid_q <= '0;
      for (int i = 0; i < RankSlots; i++) begin
        slot_id_q[i]    <= '0;
        slot_score_q[i] <= '0;
      end
    end else begin
      slot_id_q    <= slot_id_d;
      slot_score_q <= slot_score_d;
      slot_valid_q <= slot_valid_d;
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (out_space) begin
        out_valid_q <= s1_adv && is_query;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_func_q  <= req_i.func;
      s1_id_q    <= req_i.player_id;
      s1_score_q <= req_i.score;
    end
    if (out_space && s1_adv && is_query) begin
      out_rank_q <= rank_d;
    end
  end

endmodule

// ===== bench/tb_top_k_ranking_table_top.sv =====
// Self-checking testbench of the top-k ranking table with a request driver and response monitor.
`timescale 1ns / 100ps

module tb_top_k_ranking_table_top;
  import tkrt_pkg::*;

  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam score_t ScoreMin = {1'b1, {(ScoreW - 1){1'b0}}};
  localparam score_t ScoreMax = {1'b0, {(ScoreW - 1){1'b1}}};
  localparam int LongHold = 300;
  localparam int DrainCycles = 8;

  typedef struct {
    logic [FuncW-1:0] func;
    id_t              player_id;
    score_t           score;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tkrt_req_if req_if ();
  tkrt_rsp_if rsp_if ();

  top_k_ranking_table_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  request_t request_q[$];
  rank_t    expected_ranks[$];
  id_t      tbl_ident[RankSlots];
  score_t   tbl_score[RankSlots];
  logic     tbl_used[RankSlots];
  request_t next_req;
  rank_t    want_rank;
  int       n_queued = 0;
  int       n_accepted = 0;
  int       n_fail = 0;
  int       send_idle_pct = 0;
  int       rsp_stall_pct = 0;
  int       stall_token = 0;
  int       stall_seen = 0;
  int       hold_left = 0;

  task automatic clear_table();
    for (int i = 0; i < RankSlots; i++) begin
      tbl_ident[i] = '0;
      tbl_score[i] = '0;
      tbl_used[i]  = 1'b0;
    end
  endtask

  // Applies one accepted request to the table and records the rank a query returns.
  task automatic update_table(logic [FuncW-1:0] func, id_t pid, score_t sc);
    int pos;
    int found;
    pos = 0;
    found = 0;
    case (func)
      FUNC_INSERT: begin
        while (pos < RankSlots && tbl_used[pos] && tbl_score[pos] >= sc) pos++;
        if (pos < RankSlots) begin
          for (int i = RankSlots - 1; i > pos; i--) begin
            tbl_ident[i] = tbl_ident[i-1];
            tbl_score[i] = tbl_score[i-1];
            tbl_used[i]  = tbl_used[i-1];
          end
          tbl_ident[pos] = pid;
          tbl_score[pos] = sc;
          tbl_used[pos]  = 1'b1;
        end
      end
      FUNC_QUERY: begin
        for (int i = RankSlots - 1; i >= 0; i--) begin
          if (tbl_ident[i] == pid) found = i + 1;
        end
        expected_ranks = {expected_ranks, rank_t'(found)};
      end
      FUNC_CLEAR: begin
        clear_table();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        update_table(req_if.func, req_if.player_id, req_if.score);
        n_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = request_q.pop_front();
          req_if.valid     <= 1'b1;
          req_if.func      <= next_req.func;
          req_if.player_id <= next_req.player_id;
          req_if.score     <= next_req.score;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_ranks.size() == 0) begin
          $error("unexpected response: rank %0d", rsp_if.rank);
          n_fail++;
        end else begin
          want_rank = expected_ranks.pop_front();
          if (rsp_if.rank !== want_rank) begin
            $error("rank mismatch: expected %0d, actual %0d", want_rank, rsp_if.rank);
            n_fail++;
          end
        end
      end
      if (stall_token != stall_seen) begin
        stall_seen   <= stall_token;
        hold_left    <= LongHold;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  task automatic queue_request(logic [FuncW-1:0] func, id_t pid, score_t sc);
    request_t req;
    req.func = func;
    req.player_id = pid;
    req.score = sc;
    request_q = {request_q, req};
    n_queued++;
  endtask

  // Mostly inserts and queries over a small identifier pool so that lookups hit,
  // with many tied scores, the score extremes, rare clears and unused codes.
  task automatic queue_random(int n);
    int pick;
    id_t pid;
    score_t sc;
    logic [FuncW-1:0] func;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 2) func = FUNC_CLEAR;
      else if (pick < 4) func = FuncUnused;
      else if (pick < 52) func = FUNC_INSERT;
      else func = FUNC_QUERY;
      pick = $urandom_range(9);
      if (pick < 6) pid = $urandom_range(1, 24);
      else if (pick == 6) pid = '0;
      else pid = $urandom();
      pick = $urandom_range(9);
      if (pick < 4) sc = $signed($urandom_range(20)) - 10;
      else if (pick == 4) sc = ScoreMax;
      else if (pick == 5) sc = ScoreMin;
      else sc = $urandom();
      queue_request(func, pid, sc);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (n_accepted != n_queued || expected_ranks.size() != 0);
  endtask

  task automatic run_phase(int send_pct, int stall_pct, int n);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    rsp_stall_pct <= stall_pct;
    queue_random(n);
    wait_idle();
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.func = FUNC_INSERT;
    req_if.player_id = '0;
    req_if.score = '0;
    rsp_if.ready = 1'b0;
    clear_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_request(FUNC_CLEAR, 32'hFFFF_FFFF, ScoreMax);
    queue_request(FUNC_QUERY, '0, '0);
    queue_request(FUNC_QUERY, 32'hFFFF_FFFF, '0);
    queue_request(FUNC_INSERT, 32'hFFFF_FFFF, ScoreMin);
    queue_request(FUNC_INSERT, 32'd1, ScoreMax);
    queue_request(FUNC_INSERT, 32'd2, '0);
    queue_request(FUNC_INSERT, 32'd3, '0);
    queue_request(FUNC_QUERY, 32'd3, '0);
    queue_request(FUNC_QUERY, '0, '0);
    queue_request(FuncUnused, 32'd3, ScoreMax);
    queue_request(FUNC_INSERT, '0, -32'sd1);
    queue_request(FUNC_QUERY, '0, ScoreMin);
    for (int i = 0; i < 10; i++) queue_request(FUNC_INSERT, 32'd100 + i, i - 5);
    queue_request(FUNC_INSERT, 32'd200, ScoreMin);
    queue_request(FUNC_QUERY, 32'd200, '0);
    queue_request(FUNC_QUERY, 32'hFFFF_FFFF, '0);
    queue_request(FUNC_QUERY, 32'd109, '0);
    queue_request(FUNC_CLEAR, '0, '0);
    queue_request(FUNC_QUERY, 32'd1, '0);
    wait_idle();

    run_phase(0, 0, 160);
    run_phase(71, 0, 160);
    run_phase(0, 71, 160);
    run_phase(36, 36, 160);

    // The receiver holds off while queries keep coming, so the block must stall its input.
    @(posedge clk_i);
    send_idle_pct <= 0;
    rsp_stall_pct <= 0;
    stall_token <= stall_token + 1;
    for (int i = 0; i < 60; i++) queue_request(FUNC_QUERY, $urandom_range(24), $urandom());
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    if (expected_ranks.size() != 0) begin
      $error("%0d expected responses never arrived", expected_ranks.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
